>>> hw/rtl/psf_pkg.sv
// Shared constants and types of the pendulum state-feedback controller.
// No dependencies; the other files but psf_if refer to it by scoped names.

package psf_pkg;

   // Gain fraction: gains are signed Q8.24 per raw unit
   localparam int GAIN_FRAC_BITS = 24;

   // Configuration port
   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_ANGLE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_BODY_SPEED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_WHEEL_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MOTOR_CONSTANT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_WINDOW     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_WINDOW     = 3'd5;

   localparam logic signed [31:0] RST_GAIN_ANGLE       = 32'sd219927;
   localparam logic signed [31:0] RST_GAIN_BODY_SPEED  = 32'sd16082;
   localparam logic signed [31:0] RST_GAIN_WHEEL_SPEED = 32'sd3162;
   localparam logic [23:0]        RST_MOTOR_CONSTANT   = 24'd50000;
   localparam logic [14:0]        RST_ANGLE_WINDOW     = 15'd300;
   localparam logic [14:0]        RST_WHEEL_WINDOW     = 15'd3500;

   // Command codes
   localparam logic [1:0] CMD_STEADY  = 2'd0;
   localparam logic [1:0] CMD_TRACK   = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;
   localparam logic [1:0] CMD_SPARE   = 2'd3;

   // 0.002 in Q0.24
   localparam logic [15:0] LPF_WEIGHT = 16'd33554;

   // Shared multiplier: 33 x 33 signed
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_ANG,
      ST_MUL_BODY,
      ST_MUL_WHEEL,
      ST_SUM,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_MUL_LPF,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      STEP_STEADY,
      STEP_TRACK,
      STEP_RESTART,
      STEP_HALT
   } step_type;

endpackage

>>> hw/rtl/psf_if.sv
// Request and response channel interfaces of the pendulum state-feedback controller.
// No dependencies.

interface psf_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic signed [15:0] body_angle;
   logic signed [15:0] body_speed;
   logic signed [15:0] wheel_speed;
   logic signed [15:0] target_angle;
   logic signed [15:0] target_body_speed;
   logic signed [15:0] target_wheel_speed;
   logic signed [31:0] nominal_torque;

   modport source (
      output valid, cmd, body_angle, body_speed, wheel_speed,
             target_angle, target_body_speed, target_wheel_speed, nominal_torque,
      input  ready
   );
   modport sink (
      input  valid, cmd, body_angle, body_speed, wheel_speed,
             target_angle, target_body_speed, target_wheel_speed, nominal_torque,
      output ready
   );
endinterface

interface psf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] torque_out;
   logic               out_of_window;

   modport source (output valid, torque_out, out_of_window, input ready);
   modport sink   (input valid, torque_out, out_of_window, output ready);
endinterface

>>> hw/rtl/psf_mul.sv
// Shared signed multiplier with registered product, held while not enabled.
// Depends on psf_pkg for the operand and product widths.

module psf_mul (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [psf_pkg::MUL_W-1:0]    op_a,
   input  logic signed [psf_pkg::MUL_W-1:0]    op_b,
   output logic signed [psf_pkg::PROD_W-1:0]   prod
);

   logic signed [psf_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign prod = prod_ff;

endmodule

>>> hw/rtl/pendulum_state_feedback.sv
// Top level of the pendulum state-feedback controller: sequencer, accumulator,
// configuration registers and result register. Depends on psf_pkg, psf_if, psf_mul.
//
//  channel   direction  handshake          content
//  req_bus   in         valid/ready        cmd, measured and target states, nominal torque
//  rsp_bus   out        valid/ready        torque_out, out_of_window
//  csr_*     in         csr_we, no stall   register index and write data
//
// A balance or trajectory beat goes from acceptance through the angle, body and wheel
// products, the sum, then the two scaling and the low-pass products to the final step,
// which loads the result register; the single 33 x 33 multiplier takes all six in turn.
// Restart and out-of-window beats skip to the final step; beats are taken only in idle.
// Reset is synchronous and active high; it loads the register defaults and
// clears the zero-angle estimate, and ready stays low while it lasts. A stalled
// response holds its register; the next beat is taken meanwhile and waits in
// the final step for the slot.

module pendulum_state_feedback (
   input  logic                               clock,
   input  logic                               reset,
   psf_req_if.sink                            req_bus,
   psf_rsp_if.source                          rsp_bus,
   input  logic                               csr_we,
   input  logic [psf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [psf_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int MUL_W   = psf_pkg::MUL_W;
   localparam int PROD_W  = psf_pkg::PROD_W;
   // Feedback sum: three terms below 2^47 each
   localparam int ACC_W   = 51;
   localparam int SPLIT   = 24;
   localparam int MHI_W   = ACC_W - 1 - SPLIT;
   localparam int HI_W    = MHI_W + 24;
   localparam int LO_W    = SPLIT + 24;
   localparam int FULL_W  = HI_W + SPLIT + 1;
   localparam int Q_W     = 41;
   localparam int T_W     = Q_W + 2;
   localparam logic [FULL_W-1:0] MID_LIMIT = FULL_W'(1) << (Q_W - 1);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic signed [31:0] gain_angle_ff;
   logic signed [31:0] gain_body_ff;
   logic signed [31:0] gain_wheel_ff;
   logic [23:0]        motor_k_ff;
   logic [14:0]        angle_win_ff;
   logic [14:0]        wheel_win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_angle_ff <= psf_pkg::RST_GAIN_ANGLE;
         gain_body_ff  <= psf_pkg::RST_GAIN_BODY_SPEED;
         gain_wheel_ff <= psf_pkg::RST_GAIN_WHEEL_SPEED;
         motor_k_ff    <= psf_pkg::RST_MOTOR_CONSTANT;
         angle_win_ff  <= psf_pkg::RST_ANGLE_WINDOW;
         wheel_win_ff  <= psf_pkg::RST_WHEEL_WINDOW;
      end else if (csr_we) begin
         case (csr_index)
            psf_pkg::REG_GAIN_ANGLE:       gain_angle_ff <= $signed(csr_wdata[31:0]);
            psf_pkg::REG_GAIN_BODY_SPEED:  gain_body_ff  <= $signed(csr_wdata[31:0]);
            psf_pkg::REG_GAIN_WHEEL_SPEED: gain_wheel_ff <= $signed(csr_wdata[31:0]);
            psf_pkg::REG_MOTOR_CONSTANT:   motor_k_ff    <= csr_wdata[23:0];
            psf_pkg::REG_ANGLE_WINDOW:     angle_win_ff  <= csr_wdata[14:0];
            psf_pkg::REG_WHEEL_WINDOW:     wheel_win_ff  <= csr_wdata[14:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   psf_pkg::state_type state_ff, state_in;
   logic req_ready;
   logic mul_en;
   logic commit;
   logic out_valid_ff;

   psf_pkg::step_type req_kind;
   logic              accept;

   // Classify the incoming beat: restart first, then the window test
   logic signed [16:0] ang_ext, wsp_ext, ang_lim, wsp_lim;
   logic               window_fail;

   always_comb begin
      ang_ext = 17'(req_bus.body_angle);
      wsp_ext = 17'(req_bus.wheel_speed);
      ang_lim = $signed({2'b00, angle_win_ff});
      wsp_lim = $signed({2'b00, wheel_win_ff});
      window_fail = (ang_ext > ang_lim) || (ang_ext < -ang_lim) ||
                    (wsp_ext > wsp_lim) || (wsp_ext < -wsp_lim);
      if (req_bus.cmd inside {psf_pkg::CMD_RESTART, psf_pkg::CMD_SPARE}) begin
         req_kind = psf_pkg::STEP_RESTART;
      end else if (window_fail) begin
         req_kind = psf_pkg::STEP_HALT;
      end else if (req_bus.cmd == psf_pkg::CMD_STEADY) begin
         req_kind = psf_pkg::STEP_STEADY;
      end else begin
         req_kind = psf_pkg::STEP_TRACK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mul_en    = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         psf_pkg::ST_IDLE: begin
            req_ready = !reset;
            if (req_bus.valid) begin
               // restart and out-of-window beats need no arithmetic
               if (req_kind == psf_pkg::STEP_STEADY || req_kind == psf_pkg::STEP_TRACK) begin
                  state_in = psf_pkg::ST_MUL_ANG;
               end else begin
                  state_in = psf_pkg::ST_FINISH;
               end
            end
         end
         psf_pkg::ST_MUL_ANG: begin
            mul_en   = 1'b1;
            state_in = psf_pkg::ST_MUL_BODY;
         end
         psf_pkg::ST_MUL_BODY: begin
            mul_en   = 1'b1;
            state_in = psf_pkg::ST_MUL_WHEEL;
         end
         psf_pkg::ST_MUL_WHEEL: begin
            mul_en   = 1'b1;
            state_in = psf_pkg::ST_SUM;
         end
         psf_pkg::ST_SUM: begin
            state_in = psf_pkg::ST_MUL_HI;
         end
         psf_pkg::ST_MUL_HI: begin
            mul_en   = 1'b1;
            state_in = psf_pkg::ST_MUL_LO;
         end
         psf_pkg::ST_MUL_LO: begin
            mul_en   = 1'b1;
            state_in = psf_pkg::ST_MUL_LPF;
         end
         psf_pkg::ST_MUL_LPF: begin
            mul_en   = 1'b1;
            state_in = psf_pkg::ST_FINISH;
         end
         psf_pkg::ST_FINISH: begin
            // wait here until the result register is free or being emptied
            if (!out_valid_ff || rsp_bus.ready) begin
               commit   = 1'b1;
               state_in = psf_pkg::ST_IDLE;
            end
         end
         default: state_in = psf_pkg::ST_IDLE;
      endcase
   end

   assign req_bus.ready = req_ready;
   assign accept        = req_ready && req_bus.valid;

   // ---------------------------------------------------------------
   // Captured beat
   // ---------------------------------------------------------------
   psf_pkg::step_type  kind_ff;
   logic signed [15:0] ang_ff, bsp_ff, wsp_ff, t_ang_ff, t_bsp_ff, t_wsp_ff;
   logic signed [31:0] nominal_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_kind;
         ang_ff     <= req_bus.body_angle;
         bsp_ff     <= req_bus.body_speed;
         wsp_ff     <= req_bus.wheel_speed;
         t_ang_ff   <= req_bus.target_angle;
         t_bsp_ff   <= req_bus.target_body_speed;
         t_wsp_ff   <= req_bus.target_wheel_speed;
         nominal_ff <= req_bus.nominal_torque;
      end
   end

   // ---------------------------------------------------------------
   // Shared multiplier and operand selection
   // ---------------------------------------------------------------
   logic signed [31:0]     est_ff, est_in;
   logic signed [MUL_W-1:0] ang_err;
   logic signed [16:0]     d_ang, d_bsp, d_wsp;
   logic                   steady;
   logic signed [MUL_W-1:0] op_a, op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0]       acc_mag;
   logic [MHI_W-1:0]       mag_hi;
   logic [SPLIT-1:0]       mag_lo;

   assign steady  = (kind_ff == psf_pkg::STEP_STEADY);
   // angle less the zero-angle estimate, Q16.16
   assign ang_err = MUL_W'($signed({ang_ff, 16'h0000})) - MUL_W'(est_ff);
   assign d_ang   = 17'(ang_ff) - 17'(t_ang_ff);
   assign d_bsp   = 17'(bsp_ff) - 17'(t_bsp_ff);
   assign d_wsp   = 17'(wsp_ff) - 17'(t_wsp_ff);

   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign mag_hi  = acc_mag[ACC_W-2:SPLIT];
   assign mag_lo  = acc_mag[SPLIT-1:0];

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         psf_pkg::ST_MUL_ANG: begin
            op_a = MUL_W'(gain_angle_ff);
            op_b = steady ? ang_err : MUL_W'(d_ang);
         end
         psf_pkg::ST_MUL_BODY: begin
            op_a = MUL_W'(gain_body_ff);
            op_b = steady ? MUL_W'(bsp_ff) : MUL_W'(d_bsp);
         end
         psf_pkg::ST_MUL_WHEEL: begin
            op_a = MUL_W'(gain_wheel_ff);
            op_b = steady ? MUL_W'(wsp_ff) : MUL_W'(d_wsp);
         end
         psf_pkg::ST_MUL_HI: begin
            op_a = $signed({{(MUL_W-MHI_W){1'b0}}, mag_hi});
            op_b = $signed({{(MUL_W-24){1'b0}}, motor_k_ff});
         end
         psf_pkg::ST_MUL_LO: begin
            op_a = $signed({{(MUL_W-SPLIT){1'b0}}, mag_lo});
            op_b = $signed({{(MUL_W-24){1'b0}}, motor_k_ff});
         end
         psf_pkg::ST_MUL_LPF: begin
            op_a = ang_err;
            op_b = $signed({{(MUL_W-16){1'b0}}, psf_pkg::LPF_WEIGHT});
         end
         default: ;
      endcase
   end

   psf_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // ---------------------------------------------------------------
   // Feedback sum: the angle product lands while the body product is
   // issued; a steady angle term is floored from Q16.16 by 16 bits
   // ---------------------------------------------------------------
   always_comb begin
      acc_in = acc_ff;
      case (state_ff)
         psf_pkg::ST_MUL_BODY: begin
            acc_in = steady ? ACC_W'($signed(prod[PROD_W-1:16])) : $signed(prod[ACC_W-1:0]);
         end
         psf_pkg::ST_MUL_WHEEL,
         psf_pkg::ST_SUM: begin
            acc_in = acc_ff + $signed(prod[ACC_W-1:0]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // ---------------------------------------------------------------
   // Torque scaling: |S| * k split in two partial products, shifted by
   // the gain fraction, clamped, signed, feed-forward added for trajectory beats, saturated
   // ---------------------------------------------------------------
   logic [HI_W-1:0]       hi_ff;
   logic [FULL_W-1:0]     full_prod, q_full;
   logic [Q_W-1:0]        q_mag;
   logic signed [T_W-1:0] t_scaled, t_sum;
   logic signed [31:0]    t_sat;
   logic signed [31:0]    torque_ff, torque_in;

   always_ff @(posedge clock) begin
      if (state_ff == psf_pkg::ST_MUL_LO) begin
         hi_ff <= prod[HI_W-1:0];
      end
   end

   always_comb begin
      full_prod = FULL_W'({hi_ff, {SPLIT{1'b0}}}) + FULL_W'(prod[LO_W-1:0]);
      q_full    = full_prod >> psf_pkg::GAIN_FRAC_BITS;
      q_mag     = (q_full > MID_LIMIT) ? MID_LIMIT[Q_W-1:0] : q_full[Q_W-1:0];
      t_scaled  = acc_ff[ACC_W-1] ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
      t_sum     = (kind_ff == psf_pkg::STEP_TRACK) ? t_scaled + T_W'(nominal_ff) : t_scaled;
      if (t_sum[T_W-1:31] == {(T_W-31){t_sum[T_W-1]}}) begin
         t_sat = t_sum[31:0];
      end else if (t_sum[T_W-1]) begin
         t_sat = 32'sh8000_0000;
      end else begin
         t_sat = 32'sh7FFF_FFFF;
      end
   end

   always_comb begin
      torque_in = torque_ff;
      if (accept) begin
         torque_in = '0;  // holds for restart and out-of-window beats
      end else if (state_ff == psf_pkg::ST_MUL_LPF) begin
         torque_in = t_sat;
      end
   end

   always_ff @(posedge clock) begin
      torque_ff <= torque_in;
   end

   // ---------------------------------------------------------------
   // Zero-angle estimate: cleared by restart beats; on steady beats a low-pass step, product truncated toward zero
   // ---------------------------------------------------------------
   logic signed [PROD_W-1:0] lpf_bias, lpf_step;

   always_comb begin
      lpf_bias = prod[PROD_W-1] ? prod + PROD_W'(24'hFF_FFFF) : prod;
      lpf_step = lpf_bias >>> 24;
      est_in   = est_ff;
      if (commit) begin
         case (kind_ff)
            psf_pkg::STEP_STEADY:  est_in = est_ff + lpf_step[31:0];
            psf_pkg::STEP_RESTART: est_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= '0;
      end else begin
         est_ff <= est_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic signed [31:0] out_torque_ff;
   logic               out_oow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         out_torque_ff <= torque_ff;
         out_oow_ff    <= (kind_ff == psf_pkg::STEP_HALT);
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.torque_out    = out_torque_ff;
   assign rsp_bus.out_of_window = out_oow_ff;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for the pendulum state-feedback controller: directed and random beats
// against a built-in torque predictor. Depends on psf_pkg, psf_if and pendulum_state_feedback.

module tb_top;

   // Give up after this many cycles without any handshake or register write
   localparam int WATCHDOG_LIMIT = 2000;
   // Keep the log short if the block goes badly wrong
   localparam int MAX_REPORTS    = 200;

   typedef struct {
      logic [1:0]         cmd;
      logic signed [15:0] body_angle;
      logic signed [15:0] body_speed;
      logic signed [15:0] wheel_speed;
      logic signed [15:0] target_angle;
      logic signed [15:0] target_body_speed;
      logic signed [15:0] target_wheel_speed;
      logic signed [31:0] nominal_torque;
   } beat_type;

   typedef struct {
      logic signed [31:0] torque;
      logic               out_of_window;
   } torque_cmd_type;

   logic clock;
   logic reset;
   logic                          csr_we;
   logic [psf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [psf_pkg::CFG_W-1:0]     csr_wdata;

   psf_req_if req_bus ();
   psf_rsp_if rsp_bus ();

   pendulum_state_feedback u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Mirror of the controller: register copies and the zero-angle estimate (Q16.16)
   logic signed [31:0] k_angle;
   logic signed [31:0] k_body;
   logic signed [31:0] k_wheel;
   logic [23:0]        motor_k;
   logic [14:0]        angle_win;
   logic [14:0]        wheel_win;
   logic signed [31:0] zero_est;

   // Torque commands predicted for accepted beats, oldest first
   torque_cmd_type pending_commands[$];

   int idle_pct;       // chance of a gap before a beat, and (a third of it) of a stall per cycle
   int mismatch_count;
   int result_count;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647)
         return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648)
         return 32'sh80000000;
      return 32'(v);
   endfunction

   // Current-domain sum times the motor constant, dropped by the gain fraction toward zero.
   // Split the magnitude at bit 24 so nothing overflows; clip at 2^40.
   function automatic longint scale_by_motor(input longint sum);
      longint unsigned mag;
      longint unsigned hi_part;
      longint unsigned lo_part;
      longint unsigned q;
      mag     = (sum < 0) ? -sum : sum;
      hi_part = (mag >> 24) * motor_k;
      lo_part = (mag & 64'hFFFFFF) * motor_k;
      if (psf_pkg::GAIN_FRAC_BITS >= 24)
         q = (hi_part + (lo_part >> 24)) >> (psf_pkg::GAIN_FRAC_BITS - 24);
      else
         q = (hi_part << (24 - psf_pkg::GAIN_FRAC_BITS))
           + (lo_part >> psf_pkg::GAIN_FRAC_BITS);
      if (q > (64'd1 << 40))
         q = 64'd1 << 40;
      return (sum < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Work out the torque command of one beat and advance the estimate as the block would
   function automatic torque_cmd_type compute_torque_command(input beat_type s);
      longint ang, bsp, wsp, ga, gb, gw, lim_a, lim_w;
      longint err, sum, prod, est;
      longint unsigned step_mag;
      torque_cmd_type r;
      ang   = s.body_angle;
      bsp   = s.body_speed;
      wsp   = s.wheel_speed;
      ga    = k_angle;
      gb    = k_body;
      gw    = k_wheel;
      lim_a = angle_win;
      lim_w = wheel_win;
      r.torque        = '0;
      r.out_of_window = 1'b0;
      if (s.cmd == psf_pkg::CMD_RESTART || s.cmd == psf_pkg::CMD_SPARE) begin
         // restart, and the spare code that behaves as one
         zero_est = '0;
      end else if (ang > lim_a || ang < -lim_a || wsp > lim_w || wsp < -lim_w) begin
         r.out_of_window = 1'b1;
      end else if (s.cmd == psf_pkg::CMD_STEADY) begin
         est = zero_est;
         err = ang * 65536 - est;
         // angle product is Q16.16 times the gain: floor it down to the gain fraction
         sum = ((ga * err) >>> 16) + gb * bsp + gw * wsp;
         r.torque = clamp32(scale_by_motor(sum));
         // low-pass the estimate toward the angle, step truncated toward zero
         prod     = err * longint'(psf_pkg::LPF_WEIGHT);
         step_mag = (prod < 0) ? -prod : prod;
         step_mag = step_mag >> 24;
         est      = est + ((prod < 0) ? -longint'(step_mag) : longint'(step_mag));
         zero_est = 32'(est);
      end else begin
         // trajectory: errors to the target states, nominal torque fed forward
         sum = ga * (ang - longint'(s.target_angle))
             + gb * (bsp - longint'(s.target_body_speed))
             + gw * (wsp - longint'(s.target_wheel_speed));
         r.torque = clamp32(scale_by_motor(sum) + longint'(s.nominal_torque));
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Shared tasks
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch on result %0d: %s got %0d, want %0d",
                  result_count, what, got, want);
   endtask

   // Write all six registers back to back; call only with nothing in flight
   task automatic load_config(input logic [31:0] ga, input logic [31:0] gb,
                              input logic [31:0] gw, input logic [23:0] mc,
                              input logic [14:0] aw, input logic [14:0] ww);
      logic [psf_pkg::CSR_IDX_W-1:0] idx [6];
      logic [psf_pkg::CFG_W-1:0]     data [6];
      idx  = '{psf_pkg::REG_GAIN_ANGLE, psf_pkg::REG_GAIN_BODY_SPEED,
               psf_pkg::REG_GAIN_WHEEL_SPEED, psf_pkg::REG_MOTOR_CONSTANT,
               psf_pkg::REG_ANGLE_WINDOW, psf_pkg::REG_WHEEL_WINDOW};
      data = '{ga, gb, gw, 32'(mc), 32'(aw), 32'(ww)};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i];
         @(posedge clock);
      end
      csr_we    <= 1'b0;
      k_angle   = ga;
      k_body    = gb;
      k_wheel   = gw;
      motor_k   = mc;
      angle_win = aw;
      wheel_win = ww;
   endtask

   // Offer one beat, holding it until the block takes it, then record its prediction.
   // Leaves valid high; the next caller either offers another beat or drops it.
   task automatic send_step(input beat_type s);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid              <= 1'b1;
      req_bus.cmd                <= s.cmd;
      req_bus.body_angle         <= s.body_angle;
      req_bus.body_speed         <= s.body_speed;
      req_bus.wheel_speed        <= s.wheel_speed;
      req_bus.target_angle       <= s.target_angle;
      req_bus.target_body_speed  <= s.target_body_speed;
      req_bus.target_wheel_speed <= s.target_wheel_speed;
      req_bus.nominal_torque     <= s.nominal_torque;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_commands.push_back(compute_torque_command(s));
   endtask

   // Drop valid and hold until every predicted command has come back
   task automatic drain_commands();
      req_bus.valid <= 1'b0;
      while (pending_commands.size() != 0)
         @(posedge clock);
   endtask

   function automatic beat_type build_step(input logic [1:0] cmd, input int ang, input int bsp,
                                           input int wsp, input int t_ang, input int t_bsp,
                                           input int t_wsp, input int nominal);
      beat_type s;
      s.cmd                = cmd;
      s.body_angle         = 16'(ang);
      s.body_speed         = 16'(bsp);
      s.wheel_speed        = 16'(wsp);
      s.target_angle       = 16'(t_ang);
      s.target_body_speed  = 16'(t_bsp);
      s.target_wheel_speed = 16'(t_wsp);
      s.nominal_torque     = 32'(nominal);
      return s;
   endfunction

   // Mostly in-window beats so the estimate keeps moving; one in ten is a wild state
   function automatic beat_type random_step();
      beat_type s;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         s.cmd = psf_pkg::CMD_STEADY;
      else if (pick < 87)
         s.cmd = psf_pkg::CMD_TRACK;
      else if (pick < 95)
         s.cmd = psf_pkg::CMD_RESTART;
      else
         s.cmd = psf_pkg::CMD_SPARE;
      if ($urandom_range(0, 9) == 0) begin
         s.body_angle  = 16'($urandom);
         s.wheel_speed = 16'($urandom);
      end else begin
         s.body_angle  = 16'($urandom_range(0, 2 * angle_win) - angle_win);
         s.wheel_speed = 16'($urandom_range(0, 2 * wheel_win) - wheel_win);
      end
      s.body_speed         = 16'($urandom);
      s.target_angle       = 16'($urandom);
      s.target_body_speed  = 16'($urandom);
      s.target_wheel_speed = 16'($urandom);
      case ($urandom_range(0, 9))
         0:       s.nominal_torque = 32'sh7FFFFFFF;
         1:       s.nominal_torque = 32'sh80000000;
         default: s.nominal_torque = 32'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [31:0] random_gain();
      case ($urandom_range(0, 4))
         0:       return 32'h7FFFFFFF;
         1:       return 32'h80000000;
         2:       return $urandom;
         default: return 32'($urandom_range(0, 32'h200000) - 32'h100000);
      endcase
   endfunction

   function automatic logic [14:0] random_window();
      case ($urandom_range(0, 4))
         0:       return 15'h0;
         1:       return 15'h7FFF;
         2:       return 15'($urandom);
         default: return 15'($urandom_range(50, 4000));
      endcase
   endfunction

   function automatic logic [23:0] random_motor_k();
      case ($urandom_range(0, 4))
         0:       return 24'h0;
         1:       return 24'hFFFFFF;
         2:       return 24'($urandom);
         default: return 24'($urandom_range(10000, 100000));
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Reset defaults: window edges, every command, saturation in trajectory mode
   task automatic test_reset_defaults();
      idle_pct = 30;
      send_step(build_step(psf_pkg::CMD_STEADY, 0, 0, 0, 1234, -77, 999, 5));
      send_step(build_step(psf_pkg::CMD_STEADY, 300, 32767, 3500, -32768, 32767, -1,
                           32'h7FFFFFFF));
      send_step(build_step(psf_pkg::CMD_STEADY, -300, -32768, -3500, 0, 0, 0, 0));
      // just outside each window edge
      send_step(build_step(psf_pkg::CMD_STEADY, 301, 0, 0, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_STEADY, -301, 0, 0, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_TRACK, 0, 0, 3501, 0, 0, 0, 1000));
      send_step(build_step(psf_pkg::CMD_TRACK, 0, 0, -3501, 0, 0, 0, 1000));
      // trajectory pushed into both rails by the feed-forward term
      send_step(build_step(psf_pkg::CMD_TRACK, 300, 32767, 3500, -32768, -32768, -32768,
                           32'h7FFFFFFF));
      send_step(build_step(psf_pkg::CMD_TRACK, -300, -32768, -3500, 32767, 32767, 32767,
                           32'h80000000));
      // build up an estimate, then clear it by restart and by the spare code
      send_step(build_step(psf_pkg::CMD_STEADY, 200, 10, 50, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_STEADY, 200, -10, -50, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_RESTART, 32767, -32768, 32767, -1, -1, -1, -1));
      send_step(build_step(psf_pkg::CMD_STEADY, 150, 0, 0, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_SPARE, -32768, 32767, -32768, 1, 1, 1, 1));
      send_step(build_step(psf_pkg::CMD_STEADY, -150, 5, 5, 0, 0, 0, 0));
      drain_commands();
   endtask

   // Registers at their extremes: clipping at 2^40, zero windows, zero motor constant
   task automatic test_gain_extremes();
      idle_pct = 20;
      load_config(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF, 15'h7FFF, 15'h7FFF);
      send_step(build_step(psf_pkg::CMD_STEADY, 32767, 32767, 32767, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_STEADY, -32767, -32768, -32767, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_TRACK, 32767, 32767, 32767, -32768, -32768, -32768,
                           32'h80000000));
      send_step(build_step(psf_pkg::CMD_STEADY, -32768, 0, 0, 0, 0, 0, 0));
      drain_commands();

      load_config(32'h80000000, 32'h80000000, 32'h80000000, 24'h0, 15'h0, 15'h0);
      send_step(build_step(psf_pkg::CMD_STEADY, 0, 32767, 0, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_TRACK, 0, -32768, 0, 32767, 32767, 32767, 12345));
      send_step(build_step(psf_pkg::CMD_STEADY, 1, 0, 0, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_TRACK, 0, 0, -1, 0, 0, 0, 0));
      drain_commands();

      load_config(32'h80000000, 32'h80000000, 32'h80000000, 24'hFFFFFF, 15'h0, 15'h7FFF);
      send_step(build_step(psf_pkg::CMD_STEADY, 0, 32767, -32767, 0, 0, 0, 0));
      send_step(build_step(psf_pkg::CMD_RESTART, 0, 0, 0, 0, 0, 0, 0));
      drain_commands();
   endtask

   // Several random register settings, each with a different idling density
   task automatic test_random_phases();
      int density [4];
      density = '{10, 35, 0, 60};
      for (int phase = 0; phase < 4; phase++) begin
         load_config(random_gain(), random_gain(), random_gain(), random_motor_k(),
                     random_window(), random_window());
         idle_pct = density[phase];
         for (int n = 0; n < 110; n++)
            send_step(random_step());
         drain_commands();
      end
   endtask

   // Close at full rate on both sides with the default settings
   task automatic test_full_rate();
      idle_pct = 0;
      load_config(psf_pkg::RST_GAIN_ANGLE, psf_pkg::RST_GAIN_BODY_SPEED,
                  psf_pkg::RST_GAIN_WHEEL_SPEED, psf_pkg::RST_MOTOR_CONSTANT,
                  psf_pkg::RST_ANGLE_WINDOW, psf_pkg::RST_WHEEL_WINDOW);
      for (int n = 0; n < 60; n++)
         send_step(random_step());
      drain_commands();
   endtask

   // ---------------------------------------------------------------------------------------
   // Response side: random stall bursts, and the check of each returned beat
   // ---------------------------------------------------------------------------------------

   initial begin
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (idle_pct != 0 && $urandom_range(0, 299) < idle_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      torque_cmd_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         result_count++;
         if (pending_commands.size() == 0) begin
            report_mismatch("unexpected torque_out", rsp_bus.torque_out, 0);
         end else begin
            want = pending_commands.pop_front();
            if (rsp_bus.torque_out !== want.torque)
               report_mismatch("torque_out", rsp_bus.torque_out, want.torque);
            if (rsp_bus.out_of_window !== want.out_of_window)
               report_mismatch("out_of_window", rsp_bus.out_of_window, want.out_of_window);
         end
      end
   end

   // Watchdog: restart the count on any handshake or register write
   always @(posedge clock) begin
      if (reset !== 1'b0 || csr_we === 1'b1
          || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
          || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      idle_pct       = 0;
      k_angle        = psf_pkg::RST_GAIN_ANGLE;
      k_body         = psf_pkg::RST_GAIN_BODY_SPEED;
      k_wheel        = psf_pkg::RST_GAIN_WHEEL_SPEED;
      motor_k        = psf_pkg::RST_MOTOR_CONSTANT;
      angle_win      = psf_pkg::RST_ANGLE_WINDOW;
      wheel_win      = psf_pkg::RST_WHEEL_WINDOW;
      zero_est       = '0;

      reset                      <= 1'b1;
      csr_we                     <= 1'b0;
      csr_index                  <= psf_pkg::REG_GAIN_ANGLE;
      csr_wdata                  <= '0;
      req_bus.valid              <= 1'b0;
      req_bus.cmd                <= psf_pkg::CMD_STEADY;
      req_bus.body_angle         <= '0;
      req_bus.body_speed         <= '0;
      req_bus.wheel_speed        <= '0;
      req_bus.target_angle       <= '0;
      req_bus.target_body_speed  <= '0;
      req_bus.target_wheel_speed <= '0;
      req_bus.nominal_torque     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_gain_extremes();
      test_random_phases();
      test_full_rate();

      // hold a little past the block's latency to catch any stray beat
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_commands.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/psf_pkg.sv
hw/rtl/psf_if.sv
hw/rtl/psf_mul.sv
hw/rtl/pendulum_state_feedback.sv
tb/tb_top.sv
